>>> rtl/core/acc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acc_pkg - shared types and helpers for the alarm clock controller
// state, configuration and result structs, codes and time arithmetic
// ---------------------------------------------------------------------------
package acc_pkg;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // item kinds
  localparam logic [1:0] FUNC_BUTTON  = 2'd0;
  localparam logic [1:0] FUNC_POLL    = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // button mode machine
  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_CLK_HOUR   = 3'd1;
  localparam logic [2:0] MODE_CLK_MINUTE = 3'd2;
  localparam logic [2:0] MODE_ALM_HOUR   = 3'd3;
  localparam logic [2:0] MODE_ALM_MINUTE = 3'd4;
  localparam logic [2:0] MODE_SONG       = 3'd5;

  // display views
  localparam logic [1:0] VIEW_CLOCK = 2'd0;
  localparam logic [1:0] VIEW_ALARM = 2'd2;
  localparam logic [1:0] VIEW_SONG  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FLASH_WRAP  = 2'd0;
  localparam logic [1:0] CFG_CLOCK_BLANK = 2'd1;
  localparam logic [1:0] CFG_ALARM_BLANK = 2'd2;
  localparam logic [1:0] CFG_SONG_COUNT  = 2'd3;

  localparam logic [11:0] FLASH_WRAP_RST  = 12'd1000;
  localparam logic [11:0] CLOCK_BLANK_RST = 12'd100;
  localparam logic [11:0] ALARM_BLANK_RST = 12'd300;
  localparam logic [3:0]  SONG_COUNT_RST  = 4'd3;

  typedef struct packed {
    logic [11:0] flash_wrap;
    logic [11:0] clock_blank_until;
    logic [11:0] alarm_blank_until;
    logic [3:0]  song_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  view;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        show_enable;
    logic        flashing;
    logic        alarm_active;
    logic        alarm_armed;
    logic [11:0] flash_count;
    logic [2:0]  digit_index;
    logic [3:0]  song;
  } st_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] buttons;
    logic [4:0] rtc_clock_hour;
    logic [5:0] rtc_clock_minute;
    logic [4:0] rtc_alarm_hour;
    logic [5:0] rtc_alarm_minute;
  } item_t;

  // per-beat outputs that are not copies of the state
  typedef struct packed {
    logic       write_rtc;
    logic [2:0] digit_select;
    logic [3:0] digit_value;
    logic       dot_on;
    logic       next_song;
  } res_t;

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] max);
    return (v >= max) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] max);
    return (v == 6'd0 || v > max) ? max : v - 6'd1;
  endfunction

  // tens digit of a value below 64 by compare chain
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] t;
    logic [5:0] r;
    t = {2'b00, tens_of(v)};
    r = v - ((t << 3) + (t << 1));
    return r[3:0];
  endfunction

endpackage

>>> rtl/core/alarm_clock_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alarm_clock_controller - button, alarm and display controller
// two-stage registered pipeline around the per-beat state update
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in_     | input     | in_valid/in_stall  | func, buttons, rtc time and alarm
//   out_    | output    | out_valid/out_stall| rtc write flag, time values, digit,
//           |           |                    | ringing, next song pulse
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata (12 bits)
//
// one beat per cycle sustained while out_stall is low; out_valid rises once the accepted beat has
// passed the input register, then the state update into the result register
// synchronous active-low reset returns state and config registers to defaults
// out_stall holds the result register; the input register keeps accepting
// until both stages are full, so in_stall only rises when both are occupied
//
module alarm_clock_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_buttons,
  input  logic [4:0]  in_rtc_clock_hour,
  input  logic [5:0]  in_rtc_clock_minute,
  input  logic [4:0]  in_rtc_alarm_hour,
  input  logic [5:0]  in_rtc_alarm_minute,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_rtc,
  output logic [4:0]  out_clock_hour_out,
  output logic [5:0]  out_clock_minute_out,
  output logic [4:0]  out_alarm_hour_out,
  output logic [5:0]  out_alarm_minute_out,
  output logic [2:0]  out_digit_select,
  output logic [3:0]  out_digit_value,
  output logic        out_dot_on,
  output logic        out_ringing,
  output logic        out_next_song,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  acc_pkg::cfg_t  cfg_r;
  acc_pkg::st_t   st_r;
  acc_pkg::st_t   st_nxt;
  acc_pkg::item_t item_r;
  acc_pkg::res_t  res;
  acc_pkg::res_t  res_r;
  logic           item_vld_r;
  logic           out_vld_r;
  logic           adv;
  logic           in_acc;

  // the held item moves on when the result register is empty or being drained
  assign adv      = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // per-beat combinational update
  acc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_wrap        <= acc_pkg::FLASH_WRAP_RST;
      cfg_r.clock_blank_until <= acc_pkg::CLOCK_BLANK_RST;
      cfg_r.alarm_blank_until <= acc_pkg::ALARM_BLANK_RST;
      cfg_r.song_count        <= acc_pkg::SONG_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acc_pkg::CFG_FLASH_WRAP:  cfg_r.flash_wrap        <= cfg_wdata;
        acc_pkg::CFG_CLOCK_BLANK: cfg_r.clock_blank_until <= cfg_wdata;
        acc_pkg::CFG_ALARM_BLANK: cfg_r.alarm_blank_until <= cfg_wdata;
        acc_pkg::CFG_SONG_COUNT:  cfg_r.song_count        <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_acc) begin
      item_vld_r <= 1'b1;
    end else if (adv) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.func             <= in_func;
      item_r.buttons          <= in_buttons;
      item_r.rtc_clock_hour   <= in_rtc_clock_hour;
      item_r.rtc_clock_minute <= in_rtc_clock_minute;
      item_r.rtc_alarm_hour   <= in_rtc_alarm_hour;
      item_r.rtc_alarm_minute <= in_rtc_alarm_minute;
    end
  end

  // controller state commits as the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= acc_pkg::MODE_IDLE;
      st_r.view         <= acc_pkg::VIEW_CLOCK;
      st_r.clock_hour   <= '0;
      st_r.clock_minute <= '0;
      st_r.alarm_hour   <= '0;
      st_r.alarm_minute <= '0;
      st_r.show_enable  <= 1'b1;
      st_r.flashing     <= 1'b0;
      st_r.alarm_active <= 1'b0;
      st_r.alarm_armed  <= 1'b1;
      st_r.flash_count  <= '0;
      st_r.digit_index  <= 3'd1;
      st_r.song         <= 4'd1;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  acc_pkg::st_t st_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r    <= res;
      st_out_r <= st_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_write_rtc        = res_r.write_rtc;
  assign out_clock_hour_out   = st_out_r.clock_hour;
  assign out_clock_minute_out = st_out_r.clock_minute;
  assign out_alarm_hour_out   = st_out_r.alarm_hour;
  assign out_alarm_minute_out = st_out_r.alarm_minute;
  assign out_digit_select     = res_r.digit_select;
  assign out_digit_value      = res_r.digit_value;
  assign out_dot_on           = res_r.dot_on;
  assign out_ringing          = st_out_r.alarm_active;
  assign out_next_song        = res_r.next_song;

  // a committed item always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("committed beat did not reach result register");

  // input side stalls only when both stages hold a beat
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_vld_r && out_vld_r))
    else $error("input stalled with a free stage");

  // the alarm can only start ringing on an rtc poll
  a_ring_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.alarm_active) |-> $past(adv && item_r.func == acc_pkg::FUNC_POLL))
    else $error("alarm raised without rtc poll");

  // digit scan index stays on one of the four digits
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.digit_index >= 3'd1) && (st_r.digit_index <= 3'd4))
    else $error("digit index out of range");

endmodule

>>> rtl/core/acc_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acc_step - next-state and result logic for one beat
// button mode machine, rtc poll with alarm latch, display refresh
// ---------------------------------------------------------------------------
module acc_step (
  input  acc_pkg::st_t   st,
  input  acc_pkg::cfg_t  cfg,
  input  acc_pkg::item_t item,
  output acc_pkg::st_t   st_nxt,
  output acc_pkg::res_t  res
);

  logic        up, dn, md, en;
  logic [12:0] flash_inc;
  logic [11:0] fc_new;
  logic [4:0]  song_inc;
  logic        show_new;
  logic [5:0]  hr;
  logic [5:0]  mn;

  assign up = item.buttons[0];
  assign dn = item.buttons[1];
  assign md = item.buttons[2];
  assign en = item.buttons[3];

  assign flash_inc = {1'b0, st.flash_count} + 13'd1;
  assign fc_new    = (flash_inc > {1'b0, cfg.flash_wrap}) ? 12'd0 : flash_inc[11:0];
  assign song_inc  = {1'b0, st.song} + 5'd1;

  always_comb begin
    st_nxt   = st;
    res      = '0;
    show_new = st.show_enable;
    hr       = {1'b0, st.clock_hour};
    mn       = st.clock_minute;
    case (item.func)
      acc_pkg::FUNC_BUTTON: begin
        case (st.mode)
          acc_pkg::MODE_IDLE: begin
            st_nxt.view = acc_pkg::VIEW_CLOCK;
            if (up) begin
              st_nxt.flashing = 1'b1;
              st_nxt.mode     = acc_pkg::MODE_CLK_HOUR;
            end else if (dn) begin
              st_nxt.flashing = 1'b1;
              st_nxt.mode     = acc_pkg::MODE_ALM_HOUR;
              st_nxt.view     = acc_pkg::VIEW_ALARM;
            end else if (md) begin
              st_nxt.view        = acc_pkg::VIEW_SONG;
              st_nxt.mode        = acc_pkg::MODE_SONG;
              st_nxt.show_enable = 1'b0;
            end else if (en && st.alarm_active) begin
              st_nxt.alarm_active = 1'b0;
            end
          end
          acc_pkg::MODE_CLK_HOUR: begin
            if (up) begin
              st_nxt.clock_hour = 5'(acc_pkg::wrap_up({1'b0, st.clock_hour},
                                                      {1'b0, acc_pkg::HOUR_MAX}));
              res.write_rtc = 1'b1;
            end else if (dn) begin
              st_nxt.clock_hour = 5'(acc_pkg::wrap_down({1'b0, st.clock_hour},
                                                        {1'b0, acc_pkg::HOUR_MAX}));
              res.write_rtc = 1'b1;
            end else if (en) begin
              st_nxt.mode        = acc_pkg::MODE_CLK_MINUTE;
              st_nxt.show_enable = 1'b1;
              res.write_rtc      = 1'b1;
            end
          end
          acc_pkg::MODE_CLK_MINUTE: begin
            if (up) begin
              st_nxt.clock_minute = acc_pkg::wrap_up(st.clock_minute, acc_pkg::MINUTE_MAX);
              res.write_rtc = 1'b1;
            end else if (dn) begin
              st_nxt.clock_minute = acc_pkg::wrap_down(st.clock_minute, acc_pkg::MINUTE_MAX);
              res.write_rtc = 1'b1;
            end else if (en) begin
              st_nxt.mode        = acc_pkg::MODE_IDLE;
              st_nxt.show_enable = 1'b1;
              st_nxt.flashing    = 1'b0;
            end
          end
          acc_pkg::MODE_ALM_HOUR: begin
            st_nxt.view = acc_pkg::VIEW_ALARM;
            if (up) begin
              st_nxt.alarm_hour = 5'(acc_pkg::wrap_up({1'b0, st.alarm_hour},
                                                      {1'b0, acc_pkg::HOUR_MAX}));
              res.write_rtc = 1'b1;
            end else if (dn) begin
              st_nxt.alarm_hour = 5'(acc_pkg::wrap_down({1'b0, st.alarm_hour},
                                                        {1'b0, acc_pkg::HOUR_MAX}));
              res.write_rtc = 1'b1;
            end else if (en) begin
              st_nxt.mode        = acc_pkg::MODE_ALM_MINUTE;
              st_nxt.show_enable = 1'b1;
              res.write_rtc      = 1'b1;
            end
          end
          acc_pkg::MODE_ALM_MINUTE: begin
            st_nxt.view = acc_pkg::VIEW_ALARM;
            if (up) begin
              st_nxt.alarm_minute = acc_pkg::wrap_up(st.alarm_minute, acc_pkg::MINUTE_MAX);
              res.write_rtc = 1'b1;
            end else if (dn) begin
              st_nxt.alarm_minute = acc_pkg::wrap_down(st.alarm_minute, acc_pkg::MINUTE_MAX);
              res.write_rtc = 1'b1;
            end else if (en) begin
              st_nxt.mode        = acc_pkg::MODE_IDLE;
              st_nxt.show_enable = 1'b1;
              st_nxt.flashing    = 1'b0;
              res.write_rtc      = 1'b1;
            end
          end
          acc_pkg::MODE_SONG: begin
            if (md) begin
              res.next_song = 1'b1;
              st_nxt.song   = (song_inc > {1'b0, cfg.song_count}) ? 4'd1 : song_inc[3:0];
            end else if (en) begin
              st_nxt.mode        = acc_pkg::MODE_IDLE;
              st_nxt.show_enable = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      acc_pkg::FUNC_POLL: begin
        st_nxt.clock_hour   = item.rtc_clock_hour;
        st_nxt.clock_minute = item.rtc_clock_minute;
        st_nxt.alarm_hour   = item.rtc_alarm_hour;
        st_nxt.alarm_minute = item.rtc_alarm_minute;
        if (item.rtc_alarm_minute == item.rtc_clock_minute &&
            item.rtc_alarm_hour == item.rtc_clock_hour && st.alarm_armed) begin
          st_nxt.alarm_active = 1'b1;
          st_nxt.alarm_armed  = 1'b0;
        end else if (item.rtc_alarm_minute != item.rtc_clock_minute &&
                     item.rtc_alarm_hour != item.rtc_clock_hour && !st.alarm_armed) begin
          st_nxt.alarm_armed = 1'b1;
        end
      end
      acc_pkg::FUNC_REFRESH: begin
        st_nxt.flash_count = fc_new;
        if (st.view == acc_pkg::VIEW_SONG) begin
          if (st.song <= 4'd9) begin
            res.digit_select = 3'd1;
            res.digit_value  = st.song;
            res.dot_on       = 1'b1;
          end
        end else begin
          if (st.view == acc_pkg::VIEW_ALARM) begin
            if (st.flashing) show_new = (fc_new > cfg.alarm_blank_until);
            hr = {1'b0, st.alarm_hour};
            mn = st.alarm_minute;
          end else begin
            if (st.flashing) show_new = (fc_new > cfg.clock_blank_until);
          end
          st_nxt.show_enable = show_new;
          if (show_new) begin
            case (st.digit_index)
              3'd1: begin
                res.digit_select   = 3'd1;
                res.digit_value    = acc_pkg::tens_of(hr);
                st_nxt.digit_index = 3'd2;
              end
              3'd2: begin
                res.digit_select   = 3'd2;
                res.digit_value    = acc_pkg::ones_of(hr);
                res.dot_on         = 1'b1;
                st_nxt.digit_index = 3'd3;
              end
              3'd3: begin
                res.digit_select   = 3'd3;
                res.digit_value    = acc_pkg::tens_of(mn);
                st_nxt.digit_index = 3'd4;
              end
              3'd4: begin
                res.digit_select   = 3'd4;
                res.digit_value    = acc_pkg::ones_of(mn);
                st_nxt.digit_index = 3'd1;
              end
              default: st_nxt.digit_index = 3'd1;
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
